@@ design/uer_pkg.sv @@
// Package for the ultrasonic echo ranger: word types, register indexes,
// health codes and the fixed constants of the ranging arithmetic.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package uer_pkg;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_TRIGGER_PERIOD = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ECHO_TIMEOUT   = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_PULSE      = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PULSE      = 8'd3;

  localparam logic [31:0] TRIGGER_PERIOD_RESET = 32'd60000;
  localparam logic [31:0] ECHO_TIMEOUT_RESET   = 32'd30000;
  localparam logic [15:0] MIN_PULSE_RESET      = 16'd150;
  localparam logic [15:0] MAX_PULSE_RESET      = 16'd25000;

  localparam logic       CMD_TICK = 1'b0;
  localparam logic       CMD_EDGE = 1'b1;

  localparam logic [1:0] HEALTH_UNKNOWN  = 2'd0;
  localparam logic [1:0] HEALTH_OK       = 2'd1;
  localparam logic [1:0] HEALTH_DEGRADED = 2'd2;

  localparam logic [31:0] TRIG_LEN_US = 32'd10;

  // mm = (w*343 + 1000) / 2000, with /2000 as >>4 then *ceil(2^28/125) >> 28
  localparam logic [8:0]  SOUND_SCALE = 9'd343;
  localparam logic [9:0]  ROUND_BIAS  = 10'd1000;
  localparam logic [21:0] RECIP_125   = 22'd2147484;
  localparam int          RECIP_125_SHIFT = 28;
  // ms = us / 1000 as us * ceil(2^38/1000) >> 38, exact over 32 bits
  localparam logic [28:0] RECIP_1000  = 29'd274877907;
  localparam int          RECIP_1000_SHIFT = 38;

  typedef struct packed {
    logic        cmd;
    logic [31:0] time_us;
    logic        edge_high;
  } item_t;

  typedef struct packed {
    logic        trigger_level;
    logic        published;
    logic        meas_valid;
    logic [1:0]  meas_health;
    logic [31:0] meas_pulse_us;
    logic [13:0] meas_distance_mm;
    logic [31:0] meas_sequence;
    logic [22:0] meas_time_ms;
  } result_t;

  typedef struct packed {
    logic [31:0] trigger_period_us;
    logic [31:0] echo_timeout_us;
    logic [15:0] min_pulse_us;
    logic [15:0] max_pulse_us;
  } cfg_t;

  typedef struct packed {
    logic        trig;
    logic        pub;
    logic        ok;
    logic [15:0] width;
    logic [31:0] time_us;
  } event_t;

  typedef struct packed {
    logic        trig;
    logic        pub;
    logic        ok;
    logic [15:0] width;
    logic [13:0] mm;
    logic [22:0] ms;
  } conv_t;

endpackage

`default_nettype wire

@@ design/uer_ctrl.sv @@
// Phase machine of the echo ranger: trigger timing, echo capture and publish
// decisions, one word per cycle when adv is high. Depends on uer_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uer_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           adv,
  input  wire uer_pkg::item_t item,
  input  wire uer_pkg::cfg_t  cfg,
  output uer_pkg::event_t     ev
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_TRIG = 2'd1;
  localparam logic [1:0] PH_RISE = 2'd2;
  localparam logic [1:0] PH_FALL = 2'd3;

  logic [1:0]  phase, phase_next;
  logic [31:0] last_trigger_time, last_trigger_time_next;
  logic [31:0] measure_start_time, measure_start_time_next;
  logic [31:0] echo_rise_time, echo_rise_time_next;
  logic [31:0] captured_width, captured_width_next;
  logic        capture_pending, capture_pending_next;
  logic        trigger_out, trigger_out_next;
  logic        in_range;

  assign in_range = (captured_width >= {16'd0, cfg.min_pulse_us})
                 && (captured_width <= {16'd0, cfg.max_pulse_us});

  always_comb begin
    phase_next              = phase;
    last_trigger_time_next  = last_trigger_time;
    measure_start_time_next = measure_start_time;
    echo_rise_time_next     = echo_rise_time;
    captured_width_next     = captured_width;
    capture_pending_next    = capture_pending;
    trigger_out_next        = trigger_out;
    ev                      = '0;
    ev.time_us              = item.time_us;
    ev.width                = captured_width[15:0];
    priority if (item.cmd == uer_pkg::CMD_EDGE) begin
      if (item.edge_high && phase == PH_RISE) begin
        echo_rise_time_next = item.time_us;
        phase_next          = PH_FALL;
      end else if (!item.edge_high && phase == PH_FALL) begin
        captured_width_next  = item.time_us - echo_rise_time;
        phase_next           = PH_IDLE;
        capture_pending_next = 1'b1;
      end
    end else if (capture_pending) begin
      capture_pending_next = 1'b0;
      phase_next           = PH_IDLE;
      ev.pub               = 1'b1;
      ev.ok                = in_range;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          if (item.time_us - last_trigger_time >= cfg.trigger_period_us) begin
            trigger_out_next       = 1'b1;
            last_trigger_time_next = item.time_us;
            phase_next             = PH_TRIG;
          end
        end
        PH_TRIG: begin
          if (item.time_us - last_trigger_time >= uer_pkg::TRIG_LEN_US) begin
            trigger_out_next        = 1'b0;
            measure_start_time_next = item.time_us;
            phase_next              = PH_RISE;
          end
        end
        default: begin
          if (item.time_us - measure_start_time >= cfg.echo_timeout_us) begin
            ev.pub     = 1'b1;
            phase_next = PH_IDLE;
          end
        end
      endcase
    end
    ev.trig = trigger_out_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_IDLE;
      last_trigger_time  <= '0;
      measure_start_time <= '0;
      echo_rise_time     <= '0;
      captured_width     <= '0;
      capture_pending    <= 1'b0;
      trigger_out        <= 1'b0;
    end else if (adv) begin
      phase              <= phase_next;
      last_trigger_time  <= last_trigger_time_next;
      measure_start_time <= measure_start_time_next;
      echo_rise_time     <= echo_rise_time_next;
      captured_width     <= captured_width_next;
      capture_pending    <= capture_pending_next;
      trigger_out        <= trigger_out_next;
    end
  end

  a_trig_phase: assert property (@(posedge clk) disable iff (rst)
    trigger_out == (phase == PH_TRIG))
    else $error("trigger level out of step with phase");

  a_pending_idle: assert property (@(posedge clk) disable iff (rst)
    capture_pending |-> phase == PH_IDLE)
    else $error("capture pending outside idle");

endmodule

`default_nettype wire

@@ design/uer_conv.sv @@
// Ranging arithmetic: width to millimetres and microseconds to milliseconds
// by reciprocal multiplication; the first products are registered, the millimetre reciprocal product is not.
// Depends on uer_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uer_conv (
  input  wire logic            clk,
  input  wire logic            load,
  input  wire uer_pkg::event_t ev,
  output uer_pkg::conv_t       res
);

  logic        trig, pub, ok;
  logic [15:0] width;
  logic [24:0] mm_prod;
  logic [60:0] ms_prod;
  logic [42:0] mm_quot;

  always_ff @(posedge clk) begin
    if (load) begin
      trig    <= ev.trig;
      pub     <= ev.pub;
      ok      <= ev.ok;
      width   <= ev.width;
      mm_prod <= 25'(ev.width * uer_pkg::SOUND_SCALE) + 25'(uer_pkg::ROUND_BIAS);
      ms_prod <= 61'(ev.time_us * uer_pkg::RECIP_1000);
    end
  end

  assign mm_quot = 43'(mm_prod[24:4] * uer_pkg::RECIP_125);

  always_comb begin
    res       = '0;
    res.trig  = trig;
    res.pub   = pub;
    res.ok    = ok;
    res.width = width;
    res.mm    = mm_quot[uer_pkg::RECIP_125_SHIFT +: 14];
    res.ms    = ms_prod[uer_pkg::RECIP_1000_SHIFT +: 23];
  end

endmodule

`default_nettype wire

@@ design/ultrasonic_echo_ranger.sv @@
// Ultrasonic echo ranger: pipeline control, configuration registers and the
// measurement snapshot held in the result register. Depends on uer_pkg,
// uer_ctrl and uer_conv.
//
// Input words are service ticks or echo edges with a microsecond time. Each
// word is taken when item_valid is high and item_stall low, and yields one
// result word carrying the trigger level, a published flag and the current
// measurement snapshot; result_valid/result_stall move it on.
// A result passes the input register, phase machine register, multiplier
// register and result register in turn. One word is taken per cycle while
// the receiver does not stall. While the receiver stalls, the result
// register holds and the stages behind it fill; item_stall rises once all
// four are occupied.
// Configuration words are taken whenever cfg_valid is high (cfg_ready is
// always high); indexes beyond the register list are dropped.
// Reset empties the pipeline, loads the register defaults, clears all times
// and the snapshot (health unknown, sequence zero).
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_echo_ranger (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               item_valid,
  output logic                                    item_stall,
  input  wire uer_pkg::item_t                     item,
  output logic                                    result_valid,
  input  wire logic                               result_stall,
  output uer_pkg::result_t                        result,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [uer_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [uer_pkg::CFG_DATA_W-1:0]     cfg_data
);

  uer_pkg::cfg_t   cfg;
  uer_pkg::item_t  s0;
  uer_pkg::event_t ev, s1;
  uer_pkg::conv_t  cv;
  logic            s0_v, s1_v, s2_v;
  logic            out_rdy, s2_adv, s2_rdy, s1_adv, s1_rdy, s0_adv, s0_rdy, in_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_period_us <= uer_pkg::TRIGGER_PERIOD_RESET;
      cfg.echo_timeout_us   <= uer_pkg::ECHO_TIMEOUT_RESET;
      cfg.min_pulse_us      <= uer_pkg::MIN_PULSE_RESET;
      cfg.max_pulse_us      <= uer_pkg::MAX_PULSE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        uer_pkg::CFG_TRIGGER_PERIOD: cfg.trigger_period_us <= cfg_data;
        uer_pkg::CFG_ECHO_TIMEOUT:   cfg.echo_timeout_us   <= cfg_data;
        uer_pkg::CFG_MIN_PULSE:      cfg.min_pulse_us      <= cfg_data[15:0];
        uer_pkg::CFG_MAX_PULSE:      cfg.max_pulse_us      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign out_rdy    = !result_valid || !result_stall;
  assign s2_adv     = s2_v && out_rdy;
  assign s2_rdy     = !s2_v || out_rdy;
  assign s1_adv     = s1_v && s2_rdy;
  assign s1_rdy     = !s1_v || s2_rdy;
  assign s0_adv     = s0_v && s1_rdy;
  assign s0_rdy     = !s0_v || s1_rdy;
  assign item_stall = !s0_rdy;
  assign in_take    = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v         <= 1'b0;
      s1_v         <= 1'b0;
      s2_v         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s0_v         <= in_take || (s0_v && !s1_rdy);
      s1_v         <= s0_adv || (s1_v && !s2_rdy);
      s2_v         <= s1_adv || (s2_v && !out_rdy);
      result_valid <= s2_adv || (result_valid && result_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s0 <= item;
    end
    if (s0_adv) begin
      s1 <= ev;
    end
  end

  uer_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .adv  (s0_adv),
    .item (s0),
    .cfg  (cfg),
    .ev   (ev)
  );

  uer_conv u_conv (
    .clk  (clk),
    .load (s1_adv),
    .ev   (s1),
    .res  (cv)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result.trigger_level    <= 1'b0;
      result.published        <= 1'b0;
      result.meas_valid       <= 1'b0;
      result.meas_health      <= uer_pkg::HEALTH_UNKNOWN;
      result.meas_pulse_us    <= '0;
      result.meas_distance_mm <= '0;
      result.meas_sequence    <= '0;
      result.meas_time_ms     <= '0;
    end else if (s2_adv) begin
      result.trigger_level <= cv.trig;
      result.published     <= cv.pub;
      if (cv.pub) begin
        result.meas_sequence <= result.meas_sequence + 32'd1;
        result.meas_time_ms  <= cv.ms;
        result.meas_valid    <= cv.ok;
        if (cv.ok) begin
          result.meas_health      <= uer_pkg::HEALTH_OK;
          result.meas_pulse_us    <= {16'd0, cv.width};
          result.meas_distance_mm <= cv.mm;
        end else begin
          result.meas_health      <= uer_pkg::HEALTH_DEGRADED;
          result.meas_pulse_us    <= '0;
          result.meas_distance_mm <= '0;
        end
      end
    end
  end

  a_seq_step: assert property (@(posedge clk) disable iff (rst)
    (s2_adv && cv.pub) |=> result.meas_sequence == $past(result.meas_sequence) + 32'd1)
    else $error("publish did not advance the sequence");

  a_valid_ok: assert property (@(posedge clk) disable iff (rst)
    result.meas_valid |-> result.meas_health == uer_pkg::HEALTH_OK)
    else $error("valid snapshot without ok health");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    !result.meas_valid |-> (result.meas_pulse_us == 32'd0
                            && result.meas_distance_mm == 14'd0))
    else $error("invalid snapshot carries a distance");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_v && !s2_rdy) |=> s1_v)
    else $error("stalled word lost from phase stage");

endmodule

`default_nettype wire
